// ===== design/sitda_pkg.sv =====
// Shared types, constants and tables for the signed integer to decimal text converter.
package sitda_pkg;

   localparam int unsigned VALUE_W = 32;  // input integer width
   localparam int unsigned CODE_W  = 6;   // output character code width
   localparam int unsigned DIGIT_W = 4;   // one decimal digit
   localparam int unsigned POS_W   = 4;   // decimal position 0..9
   localparam int unsigned WSEL_W  = 2;   // weight step 8,4,2,1 within a digit
   localparam int unsigned TRIAL_W = 34;  // holds 8 * 10^9

   localparam logic [POS_W-1:0]  TOP_POS   = 4'd9;
   localparam logic [WSEL_W-1:0] LAST_WSEL = 2'd3;

   localparam logic [CODE_W-1:0] DIGIT_BASE = 6'd48;  // '0'
   localparam logic [CODE_W-1:0] MINUS_CODE = 6'd45;  // '-'

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture a new value
      logic sign_emit;  // put out the minus sign if the value is negative
      logic step;       // one compare/subtract step
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic conv_end;   // current step is the last weight of the units digit
   } dp_status_type;

   // Powers of ten, position 0 is the units digit
   function automatic logic [TRIAL_W-1:0] pow10(input logic [POS_W-1:0] pos);
      logic [TRIAL_W-1:0] p;
      case (pos)
         4'd0:    p = 34'd1;
         4'd1:    p = 34'd10;
         4'd2:    p = 34'd100;
         4'd3:    p = 34'd1000;
         4'd4:    p = 34'd10000;
         4'd5:    p = 34'd100000;
         4'd6:    p = 34'd1000000;
         4'd7:    p = 34'd10000000;
         4'd8:    p = 34'd100000000;
         4'd9:    p = 34'd1000000000;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

// ===== design/sitda_ctrl.sv =====
// Sequencer: sign state, then forty compare/subtract steps.
module sitda_ctrl import sitda_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SIGN = 3'b010,
      ST_CONV = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            cmd.sign_emit = 1'b1;
            state_in      = ST_CONV;
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (status.conv_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/sitda_dp.sv =====
// Magnitude register, digit builder and output register.
module sitda_dp import sitda_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output dp_status_type             status,
   output logic                      rsp_valid,
   output logic [CODE_W-1:0]         rsp_char_code,
   output logic                      rsp_last_char
);

   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [WSEL_W-1:0]  wsel_ff, wsel_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               started_ff, started_in;
   logic               valid_ff, valid_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               last_ff, last_in;

   logic [TRIAL_W-1:0] trial;
   logic [TRIAL_W-1:0] mag_wide;
   logic [TRIAL_W-1:0] diff;
   logic               ge;
   logic [DIGIT_W-1:0] weight;
   logic [DIGIT_W-1:0] digit_new;
   logic               digit_end;

   // trial = 10^pos * weight, weight 8,4,2,1
   assign trial     = pow10(pos_ff) << (LAST_WSEL - wsel_ff);
   assign mag_wide  = {{(TRIAL_W-VALUE_W){1'b0}}, mag_ff};
   assign diff      = mag_wide - trial;
   assign ge        = (mag_wide >= trial);
   assign weight    = 4'b1000 >> wsel_ff;
   assign digit_new = digit_ff | (ge ? weight : '0);
   assign digit_end = (wsel_ff == LAST_WSEL);

   assign status.conv_end = digit_end && (pos_ff == '0);

   always_comb begin
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      pos_in     = pos_ff;
      wsel_in    = wsel_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      valid_in   = 1'b0;
      code_in    = code_ff;
      last_in    = last_ff;

      if (cmd.load) begin
         neg_in     = req_value[VALUE_W-1];
         // most negative value wraps to itself, which is the right magnitude
         mag_in     = req_value[VALUE_W-1] ? (~req_value + 1'b1) : req_value;
         pos_in     = TOP_POS;
         wsel_in    = '0;
         digit_in   = '0;
         started_in = 1'b0;
      end

      if (cmd.sign_emit && neg_ff) begin
         valid_in = 1'b1;
         code_in  = MINUS_CODE;
         last_in  = 1'b0;  // at least one digit always follows
      end

      if (cmd.step) begin
         if (ge) begin
            mag_in = diff[VALUE_W-1:0];
         end
         if (digit_end) begin
            // leading zeros are dropped, the units digit always goes out
            valid_in   = started_ff || (digit_new != '0) || (pos_ff == '0);
            code_in    = DIGIT_BASE + {{(CODE_W-DIGIT_W){1'b0}}, digit_new};
            last_in    = (pos_ff == '0);
            started_in = started_ff || (digit_new != '0);
            digit_in   = '0;
            wsel_in    = '0;
            if (pos_ff != '0) begin
               pos_in = pos_ff - 1'b1;
            end
         end else begin
            digit_in = digit_new;
            wsel_in  = wsel_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pos_ff     <= '0;
         wsel_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         pos_ff     <= pos_in;
         wsel_ff    <= wsel_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      digit_ff <= digit_in;
      code_ff  <= code_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = code_ff;
   assign rsp_last_char = last_ff;

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per transfer.
//
// A value is taken when start is high and busy is low. The block then
// deals with the sign first, then with ten decimal positions of four
// compare/subtract steps each (weights 8, 4, 2, 1 times the power of ten),
// all on one 34-bit comparator and subtractor. Characters leave most
// significant first, each on rsp_char_code for exactly one cycle with
// rsp_valid high; the receiver cannot stall, so every strobed character must
// be taken on that cycle. A negative value opens with '-' (45); leading zeros
// are dropped and zero gives a single '0'. The most negative value comes out
// as -2147483648. rsp_last_char marks the final character, which appears in
// the cycle busy falls, so a new start can be issued right then.
module signed_int_to_decimal_ascii import sitda_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   output logic [CODE_W-1:0]         rsp_char_code,
   output logic                      rsp_last_char
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sitda_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   sitda_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_value     (req_value),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   // accepted transfer always starts work
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after start");

   // final character shows as the block goes idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> !busy)
      else $error("last character while still busy");

   // earlier characters only while the value is in progress
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |-> busy)
      else $error("non-final character while idle");

   // only a minus sign or a digit ever goes out
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == MINUS_CODE) ||
                    (rsp_char_code >= DIGIT_BASE && rsp_char_code <= 6'd57))
      else $error("bad character code");

endmodule
